/* rtl/assert_macros.svh */
// Assertion macros for the sprite RLE line decoder.
// Clocked on clk, disabled while rst_n is low; used by the top level only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define SRLD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true out of reset
`define SRLD_NEVER(lbl, expr, msg) \
    `SRLD_ASSERT(lbl, !(expr), msg)

`endif

/* rtl/srld_pkg.sv */
// Shared types and constants for the sprite RLE line decoder.
// No dependencies; used by srld_step and sprite_rle_line_decoder_top.
`default_nettype none

package srld_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int DIM_W     = 12;
    localparam int LEN_W     = 7;
    localparam int PIX_W     = 8;
    localparam int CNT_W     = 16;
    localparam int TAKEN_W   = 17;
    localparam int CFG_IDX_W = 2;
    localparam int TDATA_W   = 40;
    localparam int TUSER_W   = 2;

    localparam logic [DIM_W-1:0]   DIM_LIMIT = DIM_W'(MAX_DIM - 1);
    localparam logic [TAKEN_W-1:0] TAKEN_MAX = '1;

    // token flag bits
    localparam logic [7:0] TOK_SKIP   = 8'h01;
    localparam logic [7:0] TOK_REPEAT = 8'h02;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        PH_CNT_LO  = 3'd0,
        PH_CNT_HI  = 3'd1,
        PH_TOKEN   = 3'd2,
        PH_REPEAT  = 3'd3,
        PH_LITERAL = 3'd4,
        PH_DISCARD = 3'd5
    } phase_t;

    typedef struct packed {
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
    } cfg_t;

    typedef struct packed {
        logic             frame_end;
        logic             line_end;
        logic             transparent;
        logic [PIX_W-1:0] pixel_index;
        logic [LEN_W-1:0] run_len;
        logic [DIM_W-1:0] x_start;
        logic [DIM_W-1:0] row;
    } run_t;

endpackage

`default_nettype wire

/* rtl/srld_step.sv */
// Row/token state and one-byte decode step of the sprite RLE line decoder.
// Depends on srld_pkg; state advances only when en is high.
`default_nettype none

module srld_step
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic [7:0]          data_byte,
    input  wire srld_pkg::cfg_t      cfg,
    output logic                     res_valid,
    output srld_pkg::run_t           res
);

    srld_pkg::phase_t                     phase_reg, phase_next;
    logic [srld_pkg::CNT_W-1:0]           rbc_reg, rbc_next;
    logic [srld_pkg::TAKEN_W-1:0]         taken_reg, taken_next;
    logic [srld_pkg::DIM_W-1:0]           col_reg, col_next;
    logic [srld_pkg::DIM_W-1:0]           row_reg, row_next;
    logic [srld_pkg::LEN_W-1:0]           lit_reg, lit_next;
    logic [srld_pkg::CNT_W-1:0]           disc_reg, disc_next;

    logic [srld_pkg::DIM_W-1:0]           width;
    logic [srld_pkg::DIM_W-1:0]           height;
    logic [srld_pkg::DIM_W-1:0]           last_row;
    logic [srld_pkg::DIM_W-1:0]           room;
    logic [srld_pkg::TAKEN_W-1:0]         taken_inc;

    always_comb
    begin
        width    = (cfg.frame_width < srld_pkg::DIM_LIMIT) ? cfg.frame_width
                                                           : srld_pkg::DIM_LIMIT;
        height   = (cfg.frame_height < srld_pkg::DIM_LIMIT) ? cfg.frame_height
                                                            : srld_pkg::DIM_LIMIT;
        last_row = (height == '0) ? '0 : height - 1'b1;
        room     = (col_reg < width) ? width - col_reg : '0;
        taken_inc = (taken_reg == srld_pkg::TAKEN_MAX) ? taken_reg : taken_reg + 1'b1;
    end

    logic                                 fin;
    logic [srld_pkg::DIM_W-1:0]           f_start;
    logic [srld_pkg::LEN_W-1:0]           f_len;
    logic [srld_pkg::PIX_W-1:0]           f_idx;
    logic                                 f_transp;
    logic signed [srld_pkg::TAKEN_W:0]    cnt_s;
    logic signed [srld_pkg::TAKEN_W:0]    taken_s;
    logic signed [srld_pkg::TAKEN_W:0]    left_s;
    logic                                 ends;
    logic                                 fend;

    always_comb
    begin
        phase_next = phase_reg;
        rbc_next   = rbc_reg;
        taken_next = taken_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        lit_next   = lit_reg;
        disc_next  = disc_reg;
        fin        = 1'b0;
        f_start    = col_reg;
        f_len      = '0;
        f_idx      = '0;
        f_transp   = 1'b0;
        res_valid  = 1'b0;
        res        = '0;
        res.row    = row_reg;

        case (phase_reg)
            srld_pkg::PH_CNT_LO:
            begin
                rbc_next   = {rbc_reg[15:8], data_byte};
                phase_next = srld_pkg::PH_CNT_HI;
            end
            srld_pkg::PH_CNT_HI:
            begin
                rbc_next   = {data_byte, rbc_reg[7:0]};
                taken_next = '0;
                col_next   = '0;
                phase_next = srld_pkg::PH_TOKEN;
            end
            srld_pkg::PH_TOKEN:
            begin
                taken_next = taken_inc;
                if ((data_byte & srld_pkg::TOK_SKIP) != '0)
                begin
                    f_len    = (room < srld_pkg::DIM_W'(data_byte[7:1]))
                               ? room[srld_pkg::LEN_W-1:0] : data_byte[7:1];
                    col_next = col_reg + srld_pkg::DIM_W'(f_len);
                    f_transp = 1'b1;
                    fin      = 1'b1;
                end
                else
                begin
                    lit_next = srld_pkg::LEN_W'(data_byte[7:2]) + 1'b1;
                    if ((data_byte & srld_pkg::TOK_REPEAT) != '0)
                        phase_next = srld_pkg::PH_REPEAT;
                    else if (room == '0)
                        fin = 1'b1;
                    else
                        phase_next = srld_pkg::PH_LITERAL;
                end
            end
            srld_pkg::PH_REPEAT:
            begin
                taken_next = taken_inc;
                f_len      = (room < srld_pkg::DIM_W'(lit_reg))
                             ? room[srld_pkg::LEN_W-1:0] : lit_reg;
                col_next   = col_reg + srld_pkg::DIM_W'(f_len);
                f_idx      = data_byte;
                fin        = 1'b1;
            end
            srld_pkg::PH_LITERAL:
            begin
                taken_next = taken_inc;
                col_next   = col_reg + 1'b1;
                lit_next   = (lit_reg != '0) ? lit_reg - 1'b1 : lit_reg;
                f_len      = srld_pkg::LEN_W'(1);
                f_idx      = data_byte;
                if (lit_next == '0 || col_next >= width || col_next == '0)
                    fin = 1'b1;
                else
                begin
                    res_valid       = 1'b1;
                    res.x_start     = col_reg;
                    res.run_len     = f_len;
                    res.pixel_index = data_byte;
                end
            end
            srld_pkg::PH_DISCARD:
            begin
                disc_next = (disc_reg != '0) ? disc_reg - 1'b1 : disc_reg;
                if (disc_next == '0)
                    phase_next = srld_pkg::PH_CNT_LO;
            end
            default:
            begin
                phase_next = srld_pkg::PH_CNT_LO;
            end
        endcase

        // end of token: decide whether the row closes
        cnt_s   = {{2{rbc_reg[15]}}, rbc_reg};
        taken_s = {1'b0, taken_next};
        left_s  = cnt_s - taken_s;
        ends    = !(taken_s < cnt_s) || (col_next >= width);
        fend    = (row_reg >= last_row);

        if (fin)
        begin
            if (!ends)
            begin
                phase_next = srld_pkg::PH_TOKEN;
                if (f_len != '0)
                begin
                    res_valid       = 1'b1;
                    res.x_start     = f_start;
                    res.run_len     = f_len;
                    res.pixel_index = f_idx;
                    res.transparent = f_transp;
                end
            end
            else
            begin
                res_valid     = 1'b1;
                res.line_end  = 1'b1;
                res.frame_end = fend;
                if (f_len == '0)
                    res.x_start = col_next;
                else
                begin
                    res.x_start     = f_start;
                    res.run_len     = f_len;
                    res.pixel_index = f_idx;
                    res.transparent = f_transp;
                end
                if (cnt_s > taken_s)
                begin
                    disc_next  = left_s[srld_pkg::CNT_W-1:0];
                    phase_next = srld_pkg::PH_DISCARD;
                end
                else
                begin
                    disc_next  = '0;
                    phase_next = srld_pkg::PH_CNT_LO;
                end
                row_next = fend ? '0 : row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= srld_pkg::PH_CNT_LO;
            rbc_reg   <= '0;
            taken_reg <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            lit_reg   <= '0;
            disc_reg  <= '0;
        end
        else if (en)
        begin
            phase_reg <= phase_next;
            rbc_reg   <= rbc_next;
            taken_reg <= taken_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            lit_reg   <= lit_next;
            disc_reg  <= disc_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/sprite_rle_line_decoder_top.sv */
// Sprite RLE line decoder: takes one compressed byte per clock while the output
// is not held, and returns pixel runs. A byte is registered on entry and then
// decoded into the result register once the output register is free or being
// taken; one byte per clock sustained, set by the single decode step against
// the row/token state. A word held by the receiver stops the decode and, once
// the input register is full, the input.
// Depends on srld_pkg, srld_step and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sprite_rle_line_decoder_top
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // data_byte[7:0]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // row[11:0], x_start[23:12], run_len[30:24], pixel_index[38:31], zero[39]
    output logic [srld_pkg::TDATA_W-1:0]         m_tdata,
    output logic                                 m_tlast,   // line_end
    output logic [srld_pkg::TUSER_W-1:0]         m_tuser,   // transparent[0], frame_end[1]
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [srld_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [srld_pkg::DIM_W-1:0]      cfg_data
);

    srld_pkg::cfg_t  cfg_reg;
    logic            in_valid_reg;
    logic [7:0]      in_byte_reg;
    logic            out_valid_reg;
    srld_pkg::run_t  out_run_reg;
    logic            advance;
    logic            res_valid;
    srld_pkg::run_t  res;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= srld_pkg::DIM_W'(1);
            cfg_reg.frame_height <= srld_pkg::DIM_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                srld_pkg::CFG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_data;
                srld_pkg::CFG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_data;
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_byte_reg <= s_tdata;
    end

    srld_step u_step
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .data_byte (in_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= res_valid;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
            out_run_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_run_reg.pixel_index, out_run_reg.run_len,
                       out_run_reg.x_start, out_run_reg.row};
    assign m_tlast  = out_run_reg.line_end;
    assign m_tuser  = {out_run_reg.frame_end, out_run_reg.transparent};

    `SRLD_ASSERT(a_frame_end_ends_line,
                 out_valid_reg && out_run_reg.frame_end |-> out_run_reg.line_end,
                 "frame end without line end")
    `SRLD_ASSERT(a_empty_run_ends_line,
                 out_valid_reg && out_run_reg.run_len == '0 |-> out_run_reg.line_end,
                 "empty run not at row end")
    `SRLD_ASSERT(a_skip_index_zero,
                 out_valid_reg && out_run_reg.transparent |-> out_run_reg.pixel_index == '0,
                 "transparent run with index")
    `SRLD_NEVER(a_no_take_when_full,
                in_valid_reg && out_valid_reg && !m_tready && s_tready,
                "input taken with both stages blocked")

endmodule

`default_nettype wire
